// File: rtl/assert_macros.svh
// Assertion helpers for the RTL file that carries concurrent checks.
// Every check is sampled on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/adr_pkg.sv
`default_nettype none

package adr_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 24;

    // Resampler phase is unsigned Q2.24.
    localparam int FRAC_BITS  = 24;
    localparam int PHASE_BITS = 26;
    localparam logic [PHASE_BITS-1:0] RATE_STEP = 26'd18260915;
    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;

    // 0.707 in Q0.16.
    localparam logic [15:0] DOWNMIX_WEIGHT = 16'd46334;

    // At most two resampled outputs per input frame.
    localparam logic [1:0] MAX_RESULTS = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MONO_MIXDOWN    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_CHANNELS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_MODE       = 2'd2;

    typedef enum logic [1:0] {
        LAYOUT_MONO     = 2'd0,
        LAYOUT_STEREO   = 2'd1,
        LAYOUT_FIVE_ONE = 2'd2
    } layout_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mix;
        logic phase_add;
        logic rs_mul;
        logic commit;
        logic out_direct;
        logic out_interp;
        logic last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        layout_t layout;
        logic    rate_mode;
        logic    phase_due;
        logic    phase_two;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/audio_downmix_resampler.sv
// Flow: a frame is captured into the input registers, mixed into the mix registers and
// written to the output register; the single controller takes one frame at a time. A
// resampled frame adds check, multiply and emit states per output, then a commit.
// Reset: aresetn is synchronous and active low; it restores the register defaults,
// zeroes the resampler history and phase, and drops any result not yet taken.
`default_nettype none
`include "assert_macros.svh"

module audio_downmix_resampler #(
    parameter int SAMPLE_BITS = adr_pkg::SAMPLE_BITS_DEFAULT,
    localparam int S_TDATA_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [adr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [adr_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: front_left, front_right, centre, low_freq,
    // surround_left, surround_right, then zero padding.
    input  logic [S_TDATA_W-1:0]           s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: out_left, out_right, then zero padding.
    output logic [M_TDATA_W-1:0]           m_tdata,
    output logic                           m_tlast
);
    import adr_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic signed [SAMPLE_BITS-1:0] front_left, front_right, centre;
    logic signed [SAMPLE_BITS-1:0] surround_left, surround_right;
    logic signed [SAMPLE_BITS-1:0] out_left, out_right;
    logic                          out_last;

    // Unpack the input transaction. The LFE sample sits in the fourth slot and
    // is dropped by every mix, so it is never taken out of the bus.
    assign front_left     = $signed(s_tdata[0 * SAMPLE_BITS +: SAMPLE_BITS]);
    assign front_right    = $signed(s_tdata[1 * SAMPLE_BITS +: SAMPLE_BITS]);
    assign centre         = $signed(s_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS]);
    assign surround_left  = $signed(s_tdata[4 * SAMPLE_BITS +: SAMPLE_BITS]);
    assign surround_right = $signed(s_tdata[5 * SAMPLE_BITS +: SAMPLE_BITS]);

    // The controller sequences each frame: capture, mix, then either one
    // direct result or up to two interpolated results. The output register
    // lives in the datapath, so a new frame is taken while a result waits.
    adr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration registers, the two weighting
    // multipliers, the two interpolation multipliers, the resampler history
    // and phase accumulator, and the output register.
    adr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .front_left     (front_left),
        .front_right    (front_right),
        .centre         (centre),
        .surround_left  (surround_left),
        .surround_right (surround_right),
        .cmd            (cmd),
        .status         (status),
        .out_left       (out_left),
        .out_right      (out_right),
        .out_last       (out_last)
    );

    // Pack the result transaction; the unsigned concatenation zero-fills the
    // padding bits.
    assign m_tdata = M_TDATA_W'({out_right, out_left});
    assign m_tlast = out_last;

    // A result is never written over one that has not been taken.
    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, cmd.out_direct || cmd.out_interp,
                  !m_tvalid || m_tready, "output register overwritten before transfer")

    // A frame is taken one at a time: the input side closes right after a transaction.
    `ASSERT_NEXT(a_one_frame, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                 "input accepted while a frame is still in work")

    // History is committed only once the phase has dropped below one step.
    `ASSERT_IMPLY(a_commit_phase, aclk, aresetn, cmd.commit, !status.phase_due,
                  "resampler committed with a whole step of phase left")

    // The controller never issues two of load, mix, multiply, commit and output in one cycle.
    `ASSERT_ALWAYS(a_one_command, aclk, aresetn,
                   $onehot0({cmd.load_in, cmd.mix, cmd.rs_mul, cmd.commit,
                             cmd.out_direct, cmd.out_interp}),
                   "conflicting datapath commands")

endmodule

`default_nettype wire

// File: rtl/adr_ctrl.sv
`default_nettype none

module adr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             m_ready,
    output logic             m_valid,
    input  adr_pkg::status_t status,
    output adr_pkg::cmd_t    cmd
);
    import adr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_DIRECT,
        ST_CHECK,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] emit_cnt_reg, emit_cnt_next;
    logic       last_reg, last_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        emit_cnt_next = emit_cnt_reg;
        last_next     = last_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MIX;
                end
            end
            ST_MIX: begin
                cmd.mix = 1'b1;
                case (status.layout) inside
                    LAYOUT_MONO, LAYOUT_FIVE_ONE: begin
                        state_next = ST_DIRECT;
                    end
                    LAYOUT_STEREO: begin
                        if (status.rate_mode) begin
                            cmd.phase_add = 1'b1;
                            emit_cnt_next = '0;
                            state_next    = ST_CHECK;
                        end else begin
                            state_next = ST_DIRECT;
                        end
                    end
                    default: begin
                        // Unused layout code: the frame is dropped.
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIRECT: begin
                if (out_free) begin
                    cmd.out_direct = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (status.phase_due && (emit_cnt_reg != MAX_RESULTS)) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.rs_mul = 1'b1;
                // A second output follows only if the phase still covers a
                // whole step after this one.
                last_next  = !(status.phase_two && (emit_cnt_reg == '0));
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.last = last_reg;
                if (out_free) begin
                    cmd.out_interp = 1'b1;
                    emit_cnt_next  = emit_cnt_reg + 2'd1;
                    state_next     = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_direct || cmd.out_interp) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            emit_cnt_reg  <= emit_cnt_next;
            last_reg      <= last_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/adr_datapath.sv
`default_nettype none

module adr_datapath #(
    parameter int SAMPLE_BITS = adr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [adr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [adr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]      front_left,
    input  logic signed [SAMPLE_BITS-1:0]      front_right,
    input  logic signed [SAMPLE_BITS-1:0]      centre,
    input  logic signed [SAMPLE_BITS-1:0]      surround_left,
    input  logic signed [SAMPLE_BITS-1:0]      surround_right,
    input  adr_pkg::cmd_t                      cmd,
    output adr_pkg::status_t                   status,
    output logic signed [SAMPLE_BITS-1:0]      out_left,
    output logic signed [SAMPLE_BITS-1:0]      out_right,
    output logic                               out_last
);
    import adr_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + 17;
    localparam int ACC_W  = SAMPLE_BITS + 18;
    localparam int MIX_W  = SAMPLE_BITS + 19;
    localparam int IP_W   = SUM_W + FRAC_BITS + 1;

    localparam logic signed [16:0]       WEIGHT_S = {1'b0, DOWNMIX_WEIGHT};
    localparam logic signed [MIX_W-1:0]  SAT_MAX  = (MIX_W'(1) <<< (SAMPLE_BITS - 1)) - MIX_W'(1);
    localparam logic signed [MIX_W-1:0]  SAT_MIN  = -(MIX_W'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [ACC_W-1:0]  HALF_16  = ACC_W'(1) <<< 15;
    localparam logic signed [MIX_W-1:0]  HALF_17  = MIX_W'(1) <<< 16;
    localparam logic signed [IP_W-1:0]   HALF_IP  = IP_W'(1) <<< (FRAC_BITS - 1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [MIX_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[SAMPLE_BITS-1:0];
        end
        if (v < SAT_MIN) begin
            return SAT_MIN[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    logic                          cfg_mono_reg;
    layout_t                       cfg_layout_reg;
    logic                          cfg_rate_reg;
    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg, c_reg, sl_reg, sr_reg;
    logic signed [SAMPLE_BITS-1:0] cur_l_reg, cur_l_next;
    logic signed [PROD_W-1:0]      prod_l_reg, prod_r_reg, prod_l_next, prod_r_next;
    logic signed [IP_W-1:0]        ip_l_reg, ip_r_reg, ip_l_next, ip_r_next;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_r_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;
    logic                          out_last_reg;

    logic signed [SUM_W-1:0]       sum_cl, sum_cr, sum_lr, avg_wide;
    logic signed [ACC_W-1:0]       acc_l, acc_r, rnd_l, rnd_r;
    logic signed [MIX_W-1:0]       mix_sum, rnd_m;
    logic signed [SUM_W-1:0]       diff_l, diff_r;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [IP_W-1:0]        step_l, step_r;
    logic signed [SUM_W-1:0]       interp_l, interp_r;
    logic signed [SAMPLE_BITS-1:0] direct_l, direct_r;

    // Mix stage: weighted centre plus surround, and the stereo average.
    assign sum_cl      = SUM_W'(c_reg) + SUM_W'(sl_reg);
    assign sum_cr      = SUM_W'(c_reg) + SUM_W'(sr_reg);
    assign sum_lr      = SUM_W'(l_reg) + SUM_W'(r_reg);
    assign prod_l_next = sum_cl * WEIGHT_S;
    assign prod_r_next = sum_cr * WEIGHT_S;
    assign avg_wide    = (sum_lr + SUM_W'(1)) >>> 1;
    assign cur_l_next  = cfg_mono_reg ? avg_wide[SAMPLE_BITS-1:0] : l_reg;

    // Q.16 downmix sums with round half up.
    assign acc_l   = (ACC_W'(l_reg) <<< 16) + ACC_W'(prod_l_reg);
    assign acc_r   = (ACC_W'(r_reg) <<< 16) + ACC_W'(prod_r_reg);
    assign rnd_l   = (acc_l + HALF_16) >>> 16;
    assign rnd_r   = (acc_r + HALF_16) >>> 16;
    assign mix_sum = MIX_W'(acc_l) + MIX_W'(acc_r) + HALF_17;
    assign rnd_m   = mix_sum >>> 17;

    always_comb begin
        direct_l = l_reg;
        direct_r = cfg_mono_reg ? '0 : l_reg;
        case (cfg_layout_reg)
            LAYOUT_MONO: begin
                direct_l = l_reg;
                direct_r = cfg_mono_reg ? '0 : l_reg;
            end
            LAYOUT_STEREO: begin
                direct_l = cur_l_reg;
                direct_r = cfg_mono_reg ? '0 : r_reg;
            end
            LAYOUT_FIVE_ONE: begin
                direct_l = cfg_mono_reg ? sat_s(rnd_m) : sat_s(MIX_W'(rnd_l));
                direct_r = cfg_mono_reg ? '0 : sat_s(MIX_W'(rnd_r));
            end
            default: begin
                direct_l = l_reg;
                direct_r = r_reg;
            end
        endcase
    end

    // Linear interpolation: prev + round((cur - prev) * frac).
    assign frac_s    = {1'b0, phase_reg[FRAC_BITS-1:0]};
    assign diff_l    = SUM_W'(cur_l_reg) - SUM_W'(prev_l_reg);
    assign diff_r    = SUM_W'(r_reg) - SUM_W'(prev_r_reg);
    assign ip_l_next = diff_l * frac_s;
    assign ip_r_next = diff_r * frac_s;
    assign step_l    = (ip_l_reg + HALF_IP) >>> FRAC_BITS;
    assign step_r    = (ip_r_reg + HALF_IP) >>> FRAC_BITS;
    assign interp_l  = SUM_W'(prev_l_reg) + SUM_W'(step_l);
    assign interp_r  = SUM_W'(prev_r_reg) + SUM_W'(step_r);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mono_reg   <= 1'b0;
            cfg_layout_reg <= LAYOUT_STEREO;
            cfg_rate_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MONO_MIXDOWN:    cfg_mono_reg   <= cfg_wr_data[0];
                CFG_SOURCE_CHANNELS: cfg_layout_reg <= layout_t'(cfg_wr_data[1:0]);
                CFG_RATE_MODE:       cfg_rate_reg   <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            phase_reg  <= '0;
        end else begin
            if (cmd.phase_add) begin
                phase_reg <= phase_reg + RATE_STEP;
            end else if (cmd.rs_mul) begin
                phase_reg <= phase_reg - PHASE_ONE;
            end
            if (cmd.commit) begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= r_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            l_reg  <= front_left;
            r_reg  <= front_right;
            c_reg  <= centre;
            sl_reg <= surround_left;
            sr_reg <= surround_right;
        end
        if (cmd.mix) begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
            cur_l_reg  <= cur_l_next;
        end
        if (cmd.rs_mul) begin
            ip_l_reg <= ip_l_next;
            ip_r_reg <= ip_r_next;
        end
        if (cmd.out_direct) begin
            out_left_reg  <= direct_l;
            out_right_reg <= direct_r;
            out_last_reg  <= 1'b1;
        end else if (cmd.out_interp) begin
            out_left_reg  <= interp_l[SAMPLE_BITS-1:0];
            out_right_reg <= cfg_mono_reg ? '0 : interp_r[SAMPLE_BITS-1:0];
            out_last_reg  <= cmd.last;
        end
    end

    assign status.layout    = cfg_layout_reg;
    assign status.rate_mode = cfg_rate_reg;
    assign status.phase_due = |phase_reg[PHASE_BITS-1:FRAC_BITS];
    assign status.phase_two = phase_reg[FRAC_BITS+1];

    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: bench/mix_scoreboard_pkg.sv
package mix_scoreboard_pkg;

    import adr_pkg::*;

    localparam int SB = adr_pkg::SAMPLE_BITS_DEFAULT;
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    // Layout code with no meaning; frames sent under it produce nothing.
    localparam logic [1:0] LAYOUT_UNUSED = 2'd3;

    // One input frame; front left sits in the lowest bits of the bus.
    typedef struct packed {
        logic signed [SB-1:0] surr_right;
        logic signed [SB-1:0] surr_left;
        logic signed [SB-1:0] lfe;
        logic signed [SB-1:0] centre;
        logic signed [SB-1:0] right;
        logic signed [SB-1:0] left;
    } frame_t;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 last;
    } out_pair_t;

    class stereo_mix_scoreboard;
        bit                    mono_mix;
        logic [1:0]            layout;
        bit                    resample;
        longint                hist_left;
        longint                hist_right;
        logic [PHASE_BITS-1:0] phase;
        out_pair_t             expected_q[$];
        int                    mismatches;
        int                    checked;

        function new();
            mono_mix   = 1'b0;
            layout     = LAYOUT_STEREO;
            resample   = 1'b0;
            hist_left  = 0;
            hist_right = 0;
            phase      = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                CFG_MONO_MIXDOWN:    mono_mix = value[0];
                CFG_SOURCE_CHANNELS: layout   = value;
                CFG_RATE_MODE:       resample = value[0];
                default: ;
            endcase
        endfunction

        // Round half up: floor((v + 2^(s-1)) / 2^s).
        function longint round_div(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint v);
            if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
            if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
            return v;
        endfunction

        // Linear blend between the previous and current sample at fraction f.
        function longint blend(longint prev, longint cur, logic [FRAC_BITS-1:0] f);
            longint off;
            longint ff;
            longint acc;
            off = longint'(1) << (SB - 1);
            ff  = longint'(f);
            acc = (prev + off) * ((longint'(1) << FRAC_BITS) - ff) + (cur + off) * ff
                + (longint'(1) << (FRAC_BITS - 1));
            return (acc >>> FRAC_BITS) - off;
        endfunction

        function void expect_pair(longint l, longint r, bit last);
            out_pair_t p;
            p.left  = l[SB-1:0];
            p.right = r[SB-1:0];
            p.last  = last;
            expected_q.insert(expected_q.size(), p);
        endfunction

        function void note_frame(frame_t f);
            longint l;
            longint r;
            longint c;
            longint sl;
            longint sr;
            longint w;
            longint acc_l;
            longint acc_r;
            longint cur_l;
            int     n;
            logic [FRAC_BITS-1:0] frac;
            l  = longint'(f.left);
            r  = longint'(f.right);
            c  = longint'(f.centre);
            sl = longint'(f.surr_left);
            sr = longint'(f.surr_right);
            w  = longint'(DOWNMIX_WEIGHT);
            case (layout)
                LAYOUT_MONO: begin
                    expect_pair(l, mono_mix ? 0 : l, 1'b1);
                end
                LAYOUT_FIVE_ONE: begin
                    acc_l = l * 65536 + w * (c + sl);
                    acc_r = r * 65536 + w * (c + sr);
                    if (mono_mix)
                        expect_pair(clip(round_div(acc_l + acc_r, 17)), 0, 1'b1);
                    else
                        expect_pair(clip(round_div(acc_l, 16)), clip(round_div(acc_r, 16)), 1'b1);
                end
                LAYOUT_STEREO: begin
                    if (!resample) begin
                        if (mono_mix)
                            expect_pair(clip(round_div(l + r, 1)), 0, 1'b1);
                        else
                            expect_pair(l, r, 1'b1);
                    end else begin
                        cur_l = mono_mix ? clip(round_div(l + r, 1)) : l;
                        phase = phase + RATE_STEP;
                        n = 0;
                        while (phase >= PHASE_ONE && n < 2) begin
                            frac = phase[FRAC_BITS-1:0];
                            expect_pair(blend(hist_left, cur_l, frac),
                                        mono_mix ? 0 : blend(hist_right, r, frac), 1'b0);
                            n++;
                            phase = phase - PHASE_ONE;
                        end
                        if (n > 0)
                            expected_q[expected_q.size() - 1].last = 1'b1;
                        hist_left  = cur_l;
                        hist_right = r;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_output(logic signed [SB-1:0] left, logic signed [SB-1:0] right,
                                   logic last);
            out_pair_t e;
            if (expected_q.size() == 0) begin
                report("unexpected output pair (left shown)", 0, longint'(left));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (left !== e.left)
                report("out_left", longint'(e.left), longint'(left));
            if (right !== e.right)
                report("out_right", longint'(e.right), longint'(right));
            if (last !== e.last)
                report("tlast", longint'(e.last), longint'(last));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

endpackage

// File: bench/tb.sv
module tb;

    import adr_pkg::*;
    import mix_scoreboard_pkg::*;

    localparam int S_W           = ((6 * SB + 7) / 8) * 8;
    localparam int M_W           = ((2 * SB + 7) / 8) * 8;
    localparam int TARGET_FRAMES = 1400;
    // Margin for the slowest frame, one with two resampled outputs, to finish.
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic       mono;
        logic [1:0] layout;
        logic       resample;
    } setting_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // Fields from bit 0 up: front_left, front_right, centre, low_freq,
    // surround_left, surround_right.
    logic [S_W-1:0]        s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // Fields from bit 0 up: out_left, out_right.
    logic [M_W-1:0]        m_tdata;
    logic                  m_tlast;

    // Idle percentages for each side; the main sequence changes them per phase.
    int send_idle_pct  = 10;
    int recv_idle_pct  = 45;
    // Set by the main sequence once; the receiver clears it when it starts the long stall.
    bit hold_request   = 1'b0;
    int cycle_count    = 0;
    int held_cycles    = 0;
    int frames_sent    = 0;
    int settings_used  = 0;

    stereo_mix_scoreboard board;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    audio_downmix_resampler #(
        .SAMPLE_BITS(SB)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Cycle counter and watchdog. A correct run ends far below the limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results still expected.",
                 cycle_count, board.outstanding());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side. Values are read right after the rising edge, before any
    // register in the block updates, so they are the ones that edge sampled.
    // The ready is redrawn every cycle, except during the one long stall that
    // makes the block back up into its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_output(m_tdata[SB-1:0], m_tdata[2*SB-1:SB], m_tlast);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held_cycles += HOLD_CYCLES;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Registers are only written while the block is idle; all three are written
    // back to back and the predictor follows each write at its edge.
    task automatic apply_setting(setting_t s);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_MONO_MIXDOWN;
        cfg_wr_data <= CFG_DATA_W'(s.mono);
        @(posedge aclk);
        board.write_reg(CFG_MONO_MIXDOWN, CFG_DATA_W'(s.mono));
        cfg_addr    <= CFG_SOURCE_CHANNELS;
        cfg_wr_data <= s.layout;
        @(posedge aclk);
        board.write_reg(CFG_SOURCE_CHANNELS, s.layout);
        cfg_addr    <= CFG_RATE_MODE;
        cfg_wr_data <= CFG_DATA_W'(s.resample);
        @(posedge aclk);
        board.write_reg(CFG_RATE_MODE, CFG_DATA_W'(s.resample));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offers one frame and returns at the edge where the transaction completes.
    // Valid stays high into the next frame unless a random gap is drawn, so
    // back-to-back transactions occur too.
    task automatic send_frame(frame_t f);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(f);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_frame(f);
        frames_sent++;
    endtask

    // Waits for every expected result, then long enough for a frame that
    // produces nothing to finish inside the block.
    task automatic drain();
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Full-range values most of the time, with extremes, zero and small
    // values mixed in so that saturation and rounding edges are hit often.
    function automatic logic signed [SB-1:0] rand_sample();
        logic [31:0] bits;
        int unsigned pick;
        int          near_zero;
        bits      = $urandom();
        pick      = $urandom_range(99);
        near_zero = int'($urandom_range(512)) - 256;
        if (pick < 8)  return SAMPLE_MAX;
        if (pick < 16) return SAMPLE_MIN;
        if (pick < 22) return '0;
        if (pick < 40) return near_zero[SB-1:0];
        return bits[SB-1:0];
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.left       = rand_sample();
        f.right      = rand_sample();
        f.centre     = rand_sample();
        f.lfe        = rand_sample();
        f.surr_left  = rand_sample();
        f.surr_right = rand_sample();
        return f;
    endfunction

    // All fields at full scale, all at negative full scale, then alternating
    // signs so that left and right saturate in opposite directions.
    function automatic frame_t directed_frame(int k);
        frame_t f;
        case (k)
            0: f = {6{SAMPLE_MAX}};
            1: f = {6{SAMPLE_MIN}};
            default: f = {SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
        endcase
        return f;
    endfunction

    initial begin
        setting_t plan[9];
        setting_t s;
        int       seg_len;
        int       counted;
        int       pick;
        bit       pressed;

        board = new();

        // Directed settings: the reset defaults, every layout with and without
        // mixdown, the rate bit set where it must be ignored, resampling in
        // both channel modes, and the unused layout code.
        plan[0] = '{1'b0, LAYOUT_STEREO,   1'b0};
        plan[1] = '{1'b0, LAYOUT_MONO,     1'b0};
        plan[2] = '{1'b1, LAYOUT_MONO,     1'b1};
        plan[3] = '{1'b0, LAYOUT_FIVE_ONE, 1'b1};
        plan[4] = '{1'b1, LAYOUT_FIVE_ONE, 1'b0};
        plan[5] = '{1'b0, LAYOUT_STEREO,   1'b1};
        plan[6] = '{1'b1, LAYOUT_STEREO,   1'b1};
        plan[7] = '{1'b1, LAYOUT_STEREO,   1'b0};
        plan[8] = '{1'b0, LAYOUT_UNUSED,   1'b1};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the first idling pattern. The first setting is
        // the one the block comes out of reset with, so nothing is written.
        for (int i = 0; i < 9; i++) begin
            if (i > 0)
                apply_setting(plan[i]);
            for (int k = 0; k < 3; k++)
                send_frame(directed_frame(k));
            s_tvalid <= 1'b0;
            drain();
        end

        // Random part: segments of random frames, each under a random setting.
        // Resampler history and phase carry across segments, so mode changes
        // in the middle of a resampled stream are exercised as well. Frames
        // sent under the unused layout do not count toward the target.
        counted = 0;
        pressed = 1'b0;
        while (counted < TARGET_FRAMES) begin
            if (counted < TARGET_FRAMES / 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 45;
            end else if (counted < 2 * TARGET_FRAMES / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick       = $urandom_range(9);
            s.mono     = 1'($urandom_range(1));
            s.resample = 1'($urandom_range(1));
            if (pick == 0)
                s.layout = LAYOUT_UNUSED;
            else if (pick < 3)
                s.layout = LAYOUT_MONO;
            else if (pick < 5)
                s.layout = LAYOUT_FIVE_ONE;
            else
                s.layout = LAYOUT_STEREO;

            // Once, with no random idling, the receiver stalls for a long
            // stretch during a resampled stream while frames keep coming.
            if (!pressed && counted >= 2 * TARGET_FRAMES / 3) begin
                s.layout = LAYOUT_STEREO;
                s.resample = 1'b1;
            end
            apply_setting(s);
            if (!pressed && counted >= 2 * TARGET_FRAMES / 3) begin
                hold_request = 1'b1;
                pressed = 1'b1;
            end

            seg_len = (s.layout == LAYOUT_UNUSED) ? 12 : $urandom_range(30, 120);
            for (int k = 0; k < seg_len; k++)
                send_frame(random_frame());
            s_tvalid <= 1'b0;
            if (s.layout != LAYOUT_UNUSED)
                counted += seg_len;
            drain();
        end

        $display("Sent %0d frames under %0d register settings; %0d output transactions checked.",
                 frames_sent, settings_used, board.checked);
        $display("All layouts, mixdown and resampling were driven; one receiver stall of %0d cycles.",
                 held_cycles);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
